### sv/mid_pkg.sv
`default_nettype none
package mid_pkg;

    localparam int NDIM      = 3;
    localparam int NCAND     = 27;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAT_A = 2'd0,
        CFG_LAT_B = 2'd1,
        CFG_LAT_C = 2'd2
    } t_cfg_idx;

    // Levels of the pairwise compare tree over all candidates.
    localparam int NLEV = $clog2(NCAND);

    // Multiplier in {-1,0,1} of lattice vector vec for shift lane, with the
    // first vector outermost and the third innermost.
    function automatic int shift_coef(input int lane, input int vec);
        int c;
        case (vec)
            0:       c = lane / 9;
            1:       c = (lane / 3) % 3;
            default: c = lane % 3;
        endcase
        return c - 1;
    endfunction

    // Priority order for the compare tree. The unshifted lane goes first,
    // because the plain difference is the starting best and only a strictly
    // shorter candidate may replace it.
    function automatic int prio_lane(input int p);
        int l;
        if (p == 0) begin
            l = NCAND / 2;
        end else if (p <= NCAND / 2) begin
            l = p - 1;
        end else begin
            l = p;
        end
        return l;
    endfunction

    // Node count of a tree level; level 0 is the row of candidates.
    function automatic int lvl_cnt(input int g);
        int n;
        n = NCAND;
        for (int i = 0; i < g; i++) begin
            n = (n + 1) / 2;
        end
        return n;
    endfunction

    // First node of a tree level (from 1) in the flat node store.
    function automatic int lvl_off(input int g);
        int off;
        off = 0;
        for (int i = 1; i < g; i++) begin
            off = off + lvl_cnt(i);
        end
        return off;
    endfunction

    localparam int NNODE = lvl_off(NLEV + 1);

endpackage
`default_nettype wire

### sv/minimum_image_displacement.sv
// Minimum-image displacement of two points in a triclinic periodic cell.
// Input channel: i_in_valid / o_in_stall carry the two points A and C, one
// beat per cycle unless stalled. Output: o_out_valid / i_out_stall carry the
// shortest displacement A - C over all 27 shifts of the lattice vectors by
// -1, 0 or +1 each; a tie keeps the earliest shift, the plain difference first.
// Configuration: i_cfg_valid / o_cfg_ready write one lattice vector per beat,
// selected by i_cfg_index; writes to an unused index are dropped. The port is
// always ready; write it only while no beat is in flight.
// Registered stages from an input beat to its result: difference, shifted
// candidates, squares, squared lengths, then a 5-level compare tree whose
// last level is the output register. One beat is taken per cycle unless
// stalled. Every stage holds its own valid bit, and a stage loads whenever
// it is empty or the stage after it moves, so a stalled receiver freezes
// only the full tail of the pipeline and empty stages still fill. o_in_stall
// rises only when all stages hold a beat and the receiver stalls.
// Synchronous reset empties the pipeline and clears the lattice vectors.
`default_nettype none
module minimum_image_displacement #(
    parameter int COORD_WIDTH = 21
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_a_x,
    input  logic signed [COORD_WIDTH-1:0]         i_a_y,
    input  logic signed [COORD_WIDTH-1:0]         i_a_z,
    input  logic signed [COORD_WIDTH-1:0]         i_c_x,
    input  logic signed [COORD_WIDTH-1:0]         i_c_y,
    input  logic signed [COORD_WIDTH-1:0]         i_c_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [mid_pkg::OUT_W-1:0]      o_disp_x,
    output logic signed [mid_pkg::OUT_W-1:0]      o_disp_y,
    output logic signed [mid_pkg::OUT_W-1:0]      o_disp_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mid_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mid_pkg::CFG_W-1:0]             i_cfg_data
);
    import mid_pkg::*;

    localparam int CW = COORD_WIDTH + 3;
    localparam int LW = 2 * CW + 1;

    logic [CFG_W-1:0]           r_lat_a;
    logic [CFG_W-1:0]           r_lat_b;
    logic [CFG_W-1:0]           r_lat_c;
    logic [CFG_W-1:0]           w_lat [NDIM];

    logic                       w_cand_valid;
    logic                       w_cand_stall;
    logic [NDIM-1:0][CW-1:0]    w_cand_vec [NCAND];
    logic                       w_sq_valid;
    logic                       w_sq_stall;
    logic [NDIM-1:0][CW-1:0]    w_sq_vec [NCAND];
    logic [LW-1:0]              w_sq_len [NCAND];
    logic [NDIM-1:0][CW-1:0]    w_best;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_a <= '0;
            r_lat_b <= '0;
            r_lat_c <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LAT_A: r_lat_a <= i_cfg_data;
                CFG_LAT_B: r_lat_b <= i_cfg_data;
                CFG_LAT_C: r_lat_c <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign w_lat[0] = r_lat_a;
    assign w_lat[1] = r_lat_b;
    assign w_lat[2] = r_lat_c;

    mid_cand #(
        .W (COORD_WIDTH)
    ) u_cand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_c_z   (i_c_z),
        .i_lat   (w_lat),
        .o_valid (w_cand_valid),
        .i_stall (w_cand_stall),
        .o_vec   (w_cand_vec)
    );

    mid_sq #(
        .W (COORD_WIDTH)
    ) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cand_valid),
        .o_stall (w_cand_stall),
        .i_vec   (w_cand_vec),
        .o_valid (w_sq_valid),
        .i_stall (w_sq_stall),
        .o_vec   (w_sq_vec),
        .o_len   (w_sq_len)
    );

    mid_min #(
        .W (COORD_WIDTH)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_stall (w_sq_stall),
        .i_vec   (w_sq_vec),
        .i_len   (w_sq_len),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_vec   (w_best)
    );

    assign o_disp_x = OUT_W'($signed(w_best[0]));
    assign o_disp_y = OUT_W'($signed(w_best[1]));
    assign o_disp_z = OUT_W'($signed(w_best[2]));

    // The input side can only be held off when every stage is occupied.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline still had room");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

endmodule
`default_nettype wire

### sv/mid_cand.sv
`default_nettype none
module mid_cand #(
    parameter int W = 21
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [W-1:0]                    i_a_x,
    input  logic signed [W-1:0]                    i_a_y,
    input  logic signed [W-1:0]                    i_a_z,
    input  logic signed [W-1:0]                    i_c_x,
    input  logic signed [W-1:0]                    i_c_y,
    input  logic signed [W-1:0]                    i_c_z,
    input  logic [mid_pkg::CFG_W-1:0]              i_lat [mid_pkg::NDIM],
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [mid_pkg::NDIM-1:0][W+2:0]        o_vec [mid_pkg::NCAND]
);
    import mid_pkg::*;

    localparam int DW = W + 1;
    localparam int CW = W + 3;

    logic [1:0]                 r_v;
    logic [1:0]                 ld;
    logic signed [DW-1:0]       r_d [NDIM];
    logic signed [DW-1:0]       n_d [NDIM];
    logic [NDIM-1:0][CW-1:0]    r_vec [NCAND];
    logic [NDIM-1:0][CW-1:0]    n_vec [NCAND];

    always_comb begin
        ld[1] = !r_v[1] || !i_stall;
        ld[0] = !r_v[0] || ld[1];
    end

    assign o_stall = !ld[0];
    assign o_valid = r_v[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            if (ld[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_comb begin
        n_d[0] = DW'(i_a_x) - DW'(i_c_x);
        n_d[1] = DW'(i_a_y) - DW'(i_c_y);
        n_d[2] = DW'(i_a_z) - DW'(i_c_z);
    end

    // Each lane adds its own fixed combination of the lattice vectors.
    always_comb begin
        logic signed [CW-1:0] acc;
        logic signed [W-1:0]  lat;
        int                   lane;
        int                   cf;
        for (int p = 0; p < NCAND; p++) begin
            lane = prio_lane(p);
            for (int k = 0; k < NDIM; k++) begin
                acc = CW'(r_d[k]);
                for (int v = 0; v < NDIM; v++) begin
                    lat = $signed(i_lat[v][k*W +: W]);
                    cf  = shift_coef(lane, v);
                    if (cf > 0) begin
                        acc = acc + CW'(lat);
                    end else if (cf < 0) begin
                        acc = acc - CW'(lat);
                    end
                end
                n_vec[p][k] = acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_d <= n_d;
        end
        if (ld[1]) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule
`default_nettype wire

### sv/mid_sq.sv
`default_nettype none
module mid_sq #(
    parameter int W = 21
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [mid_pkg::NDIM-1:0][W+2:0]        i_vec [mid_pkg::NCAND],
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [mid_pkg::NDIM-1:0][W+2:0]        o_vec [mid_pkg::NCAND],
    output logic [2*W+6:0]                         o_len [mid_pkg::NCAND]
);
    import mid_pkg::*;

    localparam int CW = W + 3;
    localparam int SW = 2 * CW - 1;
    localparam int LW = SW + 2;

    logic [1:0]                 r_v;
    logic [1:0]                 ld;
    logic [NDIM-1:0][CW-1:0]    r_vec0 [NCAND];
    logic [NDIM-1:0][CW-1:0]    r_vec1 [NCAND];
    logic [SW-1:0]              r_sq [NCAND][NDIM];
    logic [SW-1:0]              n_sq [NCAND][NDIM];
    logic [LW-1:0]              r_len [NCAND];
    logic [LW-1:0]              n_len [NCAND];

    always_comb begin
        ld[1] = !r_v[1] || !i_stall;
        ld[0] = !r_v[0] || ld[1];
    end

    assign o_stall = !ld[0];
    assign o_valid = r_v[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            if (ld[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    // A square is never negative, so its sign bit is dropped.
    always_comb begin
        logic signed [2*CW-1:0] prod;
        for (int p = 0; p < NCAND; p++) begin
            for (int k = 0; k < NDIM; k++) begin
                prod        = $signed(i_vec[p][k]) * $signed(i_vec[p][k]);
                n_sq[p][k]  = SW'(prod);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NCAND; p++) begin
            n_len[p] = LW'(r_sq[p][0]) + LW'(r_sq[p][1]) + LW'(r_sq[p][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_sq   <= n_sq;
            r_vec0 <= i_vec;
        end
        if (ld[1]) begin
            r_len  <= n_len;
            r_vec1 <= r_vec0;
        end
    end

    assign o_vec = r_vec1;
    assign o_len = r_len;

endmodule
`default_nettype wire

### sv/mid_min.sv
`default_nettype none
module mid_min #(
    parameter int W = 21
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [mid_pkg::NDIM-1:0][W+2:0]        i_vec [mid_pkg::NCAND],
    input  logic [2*W+6:0]                         i_len [mid_pkg::NCAND],
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [mid_pkg::NDIM-1:0][W+2:0]        o_vec
);
    import mid_pkg::*;

    localparam int CW   = W + 3;
    localparam int LW   = 2 * CW + 1;
    localparam int NSRC = NCAND + NNODE;

    logic [NLEV-1:0]            r_v;
    logic [NLEV-1:0]            ld;
    logic [LW-1:0]              r_len [NNODE];
    logic [NDIM-1:0][CW-1:0]    r_vec [NNODE];
    logic [LW-1:0]              n_len [NNODE];
    logic [NDIM-1:0][CW-1:0]    n_vec [NNODE];
    logic [LW-1:0]              src_len [NSRC];
    logic [NDIM-1:0][CW-1:0]    src_vec [NSRC];

    // Candidates and tree nodes share one index space for the source side.
    for (genvar k = 0; k < NCAND; k++) begin : g_src_in
        assign src_len[k] = i_len[k];
        assign src_vec[k] = i_vec[k];
    end
    for (genvar k = 0; k < NNODE; k++) begin : g_src_node
        assign src_len[NCAND+k] = r_len[k];
        assign src_vec[NCAND+k] = r_vec[k];
    end

    // The left entry is always the earlier one, so it keeps a tie.
    for (genvar g = 1; g <= NLEV; g++) begin : g_lvl
        localparam int CNT  = lvl_cnt(g);
        localparam int PCNT = lvl_cnt(g - 1);
        localparam int OFF  = lvl_off(g);
        localparam int POFF = (g == 1) ? 0 : NCAND + lvl_off(g - 1);
        for (genvar j = 0; j < CNT; j++) begin : g_node
            if (2 * j + 1 < PCNT) begin : g_pair
                logic pick;
                assign pick = src_len[POFF+2*j+1] < src_len[POFF+2*j];
                assign n_len[OFF+j] = pick ? src_len[POFF+2*j+1] : src_len[POFF+2*j];
                assign n_vec[OFF+j] = pick ? src_vec[POFF+2*j+1] : src_vec[POFF+2*j];
            end else begin : g_single
                assign n_len[OFF+j] = src_len[POFF+2*j];
                assign n_vec[OFF+j] = src_vec[POFF+2*j];
            end
        end
    end

    always_comb begin
        ld[NLEV-1] = !r_v[NLEV-1] || !i_stall;
        for (int s = NLEV - 2; s >= 0; s--) begin
            ld[s] = !r_v[s] || ld[s+1];
        end
    end

    assign o_stall = !ld[0];
    assign o_valid = r_v[NLEV-1];
    assign o_vec   = r_vec[NNODE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NLEV; s++) begin
                if (ld[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 1; g <= NLEV; g++) begin
            for (int j = 0; j < lvl_cnt(g); j++) begin
                if (ld[g-1]) begin
                    r_len[lvl_off(g)+j] <= n_len[lvl_off(g)+j];
                    r_vec[lvl_off(g)+j] <= n_vec[lvl_off(g)+j];
                end
            end
        end
    end

endmodule
`default_nettype wire
